[sv/b64se_pkg.sv]
// ----------------------------------------------------------------------------
// b64se_pkg
// Types, register indexes and the alphabet mapping of the base64 stream
// encoder.
// ----------------------------------------------------------------------------
package b64se_pkg;

  localparam logic [1:0] REG_PAD_CHAR = 2'd0;
  localparam logic [1:0] REG_CHAR_62  = 2'd1;
  localparam logic [1:0] REG_CHAR_63  = 2'd2;

  localparam logic [7:0] PAD_CHAR_RST = 8'd45;
  localparam logic [7:0] CHAR_62_RST  = 8'd43;
  localparam logic [7:0] CHAR_63_RST  = 8'd47;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic [7:0] pad_char;
    logic [7:0] char_index_62;
    logic [7:0] char_index_63;
  } cfg_t;

  typedef struct packed {
    logic [3:0][5:0] sextet;
    logic [2:0]      nchars;
    logic            eom;
  } group_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v, input cfg_t cfg);
    logic [7:0] ch;
    begin
      if (v < 6'd26) begin
        ch = 8'(8'd65 + {2'b00, v});
      end else if (v < 6'd52) begin
        ch = 8'(8'd97 + {2'b00, v} - 8'd26);
      end else if (v < 6'd62) begin
        ch = 8'(8'd48 + {2'b00, v} - 8'd52);
      end else if (v == 6'd62) begin
        ch = cfg.char_index_62;
      end else begin
        ch = cfg.char_index_63;
      end
      return ch;
    end
  endfunction

endpackage

[sv/base64_stream_encoder.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder: one message byte in, alphabet characters out.
// ----------------------------------------------------------------------------
// Input queue side: present item and raise push while full is low; one byte
// is taken per such edge. end_of_message on a byte closes the message and
// pads a partial group with the pad character.
// Result queue side: while empty is low, result holds the oldest character;
// pop takes it. Every third byte, or a marked byte, yields four characters,
// with last_char set on the fourth character of a marked group.
// The group that a byte closes is written into the group queue, and its
// first character is then loaded into the output register. The serializer
// emits one character per cycle while the receiver keeps popping; the group
// queue (GRP_DEPTH entries) lets input continue while characters drain.
// A stalled receiver holds the output register, then fills the group queue,
// then raises full. Reset empties both sides, drops any partial group and
// restores the pad and index 62/63 characters; cfg_write updates them.
// ----------------------------------------------------------------------------
module base64_stream_encoder import b64se_pkg::*; #(
  parameter int GRP_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_item_t   item,
  output logic       empty,
  input  logic       pop,
  output out_item_t  result,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t   cfg;
  logic   accept;
  logic   grp_push;
  group_t grp_wr;
  group_t grp_rd;
  logic   grp_full;
  logic   grp_empty;
  logic   grp_pop;

  assign full   = grp_full;
  assign accept = push && !grp_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pad_char      <= PAD_CHAR_RST;
      cfg.char_index_62 <= CHAR_62_RST;
      cfg.char_index_63 <= CHAR_63_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PAD_CHAR: cfg.pad_char      <= cfg_data;
        REG_CHAR_62:  cfg.char_index_62 <= cfg_data;
        REG_CHAR_63:  cfg.char_index_63 <= cfg_data;
        default: ;
      endcase
    end
  end

  b64se_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .grp_push (grp_push),
    .grp      (grp_wr)
  );

  b64se_fifo #(
    .DEPTH (GRP_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (grp_push),
    .wr_data (grp_wr),
    .full    (grp_full),
    .rd_en   (grp_pop),
    .rd_data (grp_rd),
    .empty   (grp_empty)
  );

  b64se_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .grp_empty (grp_empty),
    .grp       (grp_rd),
    .grp_pop   (grp_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

[sv/b64se_front.sv]
// ----------------------------------------------------------------------------
// b64se_front
// Gathers bytes into groups of up to three and splits each finished group into
// four sextets with its character count.
// ----------------------------------------------------------------------------
module b64se_front import b64se_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  output logic     grp_push,
  output group_t   grp
);

  logic [7:0] pending0;
  logic [7:0] pending1;
  logic [1:0] pending_count;
  logic [7:0] g0, g1, g2;
  logic       store;

  assign store    = (pending_count != 2'd2) && !item.end_of_message;
  assign grp_push = accept && !store;

  always_comb begin
    unique case (pending_count)
      2'd0: begin
        g0 = item.data_byte;
        g1 = 8'd0;
        g2 = 8'd0;
      end
      2'd1: begin
        g0 = pending0;
        g1 = item.data_byte;
        g2 = 8'd0;
      end
      default: begin
        g0 = pending0;
        g1 = pending1;
        g2 = item.data_byte;
      end
    endcase
  end

  always_comb begin
    grp.sextet[0] = g0[7:2];
    grp.sextet[1] = {g0[1:0], g1[7:4]};
    grp.sextet[2] = {g1[3:0], g2[7:6]};
    grp.sextet[3] = g2[5:0];
    grp.nchars    = (pending_count == 2'd2) ? 3'd4 : 3'(pending_count + 2'd2);
    grp.eom       = item.end_of_message;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
    end else if (accept) begin
      if (store) begin
        pending_count <= 2'(pending_count + 2'd1);
      end else begin
        pending_count <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) begin
      if (pending_count == 2'd0) begin
        pending0 <= item.data_byte;
      end else begin
        pending1 <= item.data_byte;
      end
    end
  end

endmodule

[sv/b64se_fifo.sv]
// ----------------------------------------------------------------------------
// b64se_fifo
// Short queue of finished groups between the gathering and the output side.
// ----------------------------------------------------------------------------
module b64se_fifo import b64se_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  group_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output group_t rd_data,
  output logic   empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      if (do_wr && !do_rd) begin
        count <= CW'(count + 1'b1);
      end else if (do_rd && !do_wr) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

[sv/b64se_back.sv]
// ----------------------------------------------------------------------------
// b64se_back
// Emits the four characters of each queued group into an output register,
// one per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module b64se_back import b64se_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      grp_empty,
  input  group_t    grp,
  output logic      grp_pop,
  output out_item_t result,
  output logic      empty,
  input  logic      pop
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  out_item_t  result_next;

  assign empty   = !out_valid;
  assign load    = (!out_valid || pop) && !grp_empty;
  assign grp_pop = load && (idx == 2'd3);

  always_comb begin
    result_next.out_char  = ({1'b0, idx} < grp.nchars) ?
                            sextet_to_char(grp.sextet[idx], cfg) : cfg.pad_char;
    result_next.last_char = grp.eom && (idx == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= 2'(idx + 2'd1);
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule
